// ----- rtl/core/mpd_pkg.sv -----
// package: types and constants of the program stream demultiplexer
`timescale 1ns / 1ps
package mpd_pkg;

    localparam int STAMP_W = 33;

    localparam logic [2:0] EV_PAYLOAD   = 3'd0;
    localparam logic [2:0] EV_PROG_END  = 3'd1;
    localparam logic [2:0] EV_NOT_MPEG  = 3'd2;
    localparam logic [2:0] EV_ENCRYPTED = 3'd3;
    localparam logic [2:0] EV_BAD_HDR   = 3'd4;

    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_MPEG1   = 2'd1;
    localparam logic [1:0] VER_MPEG2   = 2'd2;
    localparam logic [1:0] VER_RAW     = 2'd3;

    localparam logic [1:0] CFG_VIDEO_SEL = 2'd0;
    localparam logic [1:0] CFG_AUDIO_SEL = 2'd1;
    localparam logic [1:0] CFG_RAW_START = 2'd2;

    localparam logic [7:0] ID_PROG_END = 8'hb9;
    localparam logic [7:0] ID_PACK     = 8'hba;
    localparam logic [7:0] ID_RAW_LO   = 8'ha0;

    // one result item
    typedef struct packed {
        logic [2:0]         event_res;
        logic [7:0]         payload_byte;
        logic               to_audio;
        logic               stamp_valid;
        logic [STAMP_W-1:0] pts;
        logic [STAMP_W-1:0] dts;
        logic               packet_first;
        logic               packet_last;
        logic [1:0]         mpeg_version;
    } res_t;

    function automatic logic [STAMP_W-1:0] decode_stamp(input logic [39:0] s);
        return {s[35:33], s[31:17], s[15:1]};
    endfunction

endpackage

// ----- rtl/core/mpeg_ps_pes_demux_core.sv -----
// top level of the program stream demultiplexer
`timescale 1ns / 1ps
// Usage:
// s_axis_* takes one stream byte per item in tdata; m_axis_* gives at most one
// result item per byte. Configuration goes through cfg_we/cfg_addr/cfg_wdata
// while the block is idle: 0 video stream, 1 audio stream, 2 raw start.
// Each result is registered into a result queue of QUEUE_DEPTH entries and
// reaches m_axis once the items ahead of it are taken. The parser decides
// each byte combinationally; throughput is one byte per cycle while the queue
// has space. When the receiver stalls the queue fills; s_axis_tready drops
// while all QUEUE_DEPTH entries are taken, and returns as items drain.
// Reset clears the parser to the start code hunt, empties the queue and sets
// the registers to zero. After program end or a bad pack header the block
// keeps accepting bytes but gives no more results until reset.
module mpeg_ps_pes_demux_core
    import mpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [1:0]    cfg_addr,
    input  logic [4:0]    cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,  // data_byte
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // event_res, payload_byte, to_audio, stamp_valid, pts, dts, packet_first,
    // mpeg_version, zero fill
    output logic [87:0]   m_axis_tdata,
    output logic          m_axis_tlast   // packet_last
);

    logic [3:0] video_sel_reg;
    logic [4:0] audio_sel_reg;
    logic       raw_start_reg;
    logic       res_valid;
    res_t       res, q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            video_sel_reg <= '0;
            audio_sel_reg <= '0;
            raw_start_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_VIDEO_SEL: video_sel_reg <= cfg_wdata[3:0];
                CFG_AUDIO_SEL: audio_sel_reg <= cfg_wdata;
                CFG_RAW_START: raw_start_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    mpd_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_valid(s_axis_tvalid && s_axis_tready),
        .byte_data (s_axis_tdata),
        .video_sel (video_sel_reg),
        .audio_sel (audio_sel_reg),
        .raw_start (raw_start_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    mpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(res_valid),
        .wr_data (res),
        .space   (s_axis_tready),
        .rd_valid(m_axis_tvalid),
        .rd_ready(m_axis_tready),
        .rd_data (q_data)
    );

    assign m_axis_tdata = {6'd0, q_data.mpeg_version, q_data.packet_first, q_data.dts,
                           q_data.pts, q_data.stamp_valid, q_data.to_audio,
                           q_data.payload_byte, q_data.event_res};
    assign m_axis_tlast = q_data.packet_last;

endmodule

// ----- rtl/core/mpd_parse.sv -----
// front part: start code hunt, header parsing and classification of each byte
`timescale 1ns / 1ps
module mpd_parse
    import mpd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic [3:0] video_sel,
    input  logic [4:0] audio_sel,
    input  logic       raw_start,
    output logic       res_valid,
    output res_t       res
);

    localparam logic [3:0] PH_HUNT       = 4'd0;
    localparam logic [3:0] PH_PACK_B4    = 4'd1;
    localparam logic [3:0] PH_PACK_FIX   = 4'd2;
    localparam logic [3:0] PH_PACK_STUFF = 4'd3;
    localparam logic [3:0] PH_LEN_HI     = 4'd4;
    localparam logic [3:0] PH_LEN_LO     = 4'd5;
    localparam logic [3:0] PH_SKIP       = 4'd6;
    localparam logic [3:0] PH_PAYLOAD    = 4'd7;
    localparam logic [3:0] PH_PES_STUFF  = 4'd8;
    localparam logic [3:0] PH_PES_BUF    = 4'd9;
    localparam logic [3:0] PH_PES_MARK   = 4'd10;
    localparam logic [3:0] PH_PES_FLAGS  = 4'd11;
    localparam logic [3:0] PH_PES_HLEN   = 4'd12;
    localparam logic [3:0] PH_PES_STAMP  = 4'd13;
    localparam logic [3:0] PH_PES_HSKIP  = 4'd14;

    logic [23:0]        sync_reg, sync_next;
    logic [3:0]         phase_reg, phase_next;
    logic [7:0]         id_reg, id_next;
    logic [16:0]        left_reg, left_next;
    logic [7:0]         hleft_reg, hleft_next;
    logic [39:0]        shift_reg, shift_next;
    logic [STAMP_W-1:0] pts_reg, pts_next, dts_reg, dts_next;
    logic [1:0]         ver_reg, ver_next;
    logic               halt_reg, halt_next;
    logic [3:0]         scnt_reg, scnt_next;
    logic               dtsf_reg, dtsf_next, m2_reg, m2_next;
    logic               hval_reg, hval_next, first_reg, first_next;

    logic               raw;
    logic               aud;
    logic               sel_hit;
    logic [3:0]         need;
    logic [16:0]        left_dec;
    logic [3:0]         scnt_dec;
    logic [7:0]         hleft_dec;
    logic [39:0]        shift_in;
    logic               ev_on;
    logic [2:0]         ev;
    logic               mark_on;
    logic [7:0]         mark_c;

    assign raw      = raw_start || (ver_reg == VER_RAW);
    assign aud      = (id_reg[7:5] == 3'b110);
    assign sel_hit  = (id_reg[7:5] == 3'b110 && id_reg[4:0] == audio_sel) ||
                      (id_reg[7:4] == 4'he && id_reg[3:0] == video_sel);
    assign left_dec = (left_reg != 17'd0) ? left_reg - 17'd1 : left_reg;
    assign scnt_dec = (scnt_reg != 4'd0) ? scnt_reg - 4'd1 : scnt_reg;
    assign hleft_dec = (hleft_reg != 8'd0) ? hleft_reg - 8'd1 : hleft_reg;
    assign shift_in = {shift_reg[31:0], byte_data};
    assign need     = (shift_reg[7:6] == 2'b10) ? 4'd5 :
                      (shift_reg[7:6] == 2'b11) ? 4'd10 : 4'd0;

    always_comb begin
        sync_next  = sync_reg;
        phase_next = phase_reg;
        id_next    = id_reg;
        left_next  = left_reg;
        hleft_next = hleft_reg;
        shift_next = shift_reg;
        pts_next   = pts_reg;
        dts_next   = dts_reg;
        ver_next   = ver_reg;
        halt_next  = halt_reg;
        scnt_next  = scnt_reg;
        dtsf_next  = dtsf_reg;
        m2_next    = m2_reg;
        hval_next  = hval_reg;
        first_next = first_reg;
        res_valid  = 1'b0;
        res        = '0;
        res.mpeg_version = raw ? VER_RAW : ver_reg;
        ev_on      = 1'b0;
        ev         = EV_BAD_HDR;
        mark_on    = 1'b0;
        mark_c     = byte_data;

        if (byte_valid && !halt_reg) begin
            if (raw) begin
                res_valid        = 1'b1;
                res.payload_byte = byte_data;
            end else if (phase_reg < PH_PES_STUFF || phase_reg == 4'd15) begin
                unique case (phase_reg)
                    PH_HUNT: begin
                        if (sync_reg != 24'h000001) begin
                            sync_next = {sync_reg[15:0], byte_data};
                        end else begin
                            sync_next = 24'hffffff;
                            id_next   = byte_data;
                            if (byte_data == ID_PROG_END) begin
                                halt_next     = 1'b1;
                                res_valid     = 1'b1;
                                res.event_res = EV_PROG_END;
                            end else if (byte_data == ID_PACK) begin
                                phase_next = PH_PACK_B4;
                            end else if (byte_data >= ID_RAW_LO &&
                                         byte_data < ID_PROG_END) begin
                                ver_next         = VER_RAW;
                                res_valid        = 1'b1;
                                res.payload_byte = byte_data;
                                res.packet_first = 1'b1;
                                res.mpeg_version = VER_RAW;
                            end else begin
                                phase_next = PH_LEN_HI;
                            end
                        end
                    end
                    PH_PACK_B4: begin
                        if (byte_data[7:6] == 2'b01) begin
                            ver_next   = VER_MPEG2;
                            hleft_next = 8'd8;
                            phase_next = PH_PACK_FIX;
                        end else if (byte_data[7:4] == 4'h2) begin
                            ver_next   = VER_MPEG1;
                            left_next  = 17'd7;
                            phase_next = PH_SKIP;
                        end else begin
                            halt_next     = 1'b1;
                            res_valid     = 1'b1;
                            res.event_res = EV_NOT_MPEG;
                        end
                    end
                    PH_PACK_FIX: begin
                        hleft_next = hleft_reg - 8'd1;
                        if (hleft_next == 8'd0) phase_next = PH_PACK_STUFF;
                    end
                    PH_PACK_STUFF: begin
                        left_next  = {14'd0, byte_data[2:0]};
                        phase_next = (byte_data[2:0] == 3'd0) ? PH_HUNT : PH_SKIP;
                    end
                    PH_LEN_HI: begin
                        left_next  = {1'b0, byte_data, 8'd0};
                        phase_next = PH_LEN_LO;
                    end
                    PH_LEN_LO: begin
                        left_next = {left_reg[16:8], byte_data};
                        if (sel_hit) begin
                            pts_next  = '0;
                            dts_next  = '0;
                            hval_next = 1'b0;
                            m2_next   = 1'b0;
                            if (left_next == 17'd0) begin
                                phase_next    = PH_HUNT;
                                res_valid     = 1'b1;
                                res.event_res = EV_BAD_HDR;
                            end else begin
                                phase_next = PH_PES_STUFF;
                            end
                        end else begin
                            phase_next = (left_next == 17'd0) ? PH_HUNT : PH_SKIP;
                        end
                    end
                    PH_SKIP: begin
                        left_next = left_dec;
                        if (left_dec == 17'd0) phase_next = PH_HUNT;
                    end
                    PH_PAYLOAD: begin
                        left_next  = left_dec;
                        first_next = 1'b0;
                        if (left_dec == 17'd0) phase_next = PH_HUNT;
                        res_valid        = 1'b1;
                        res.payload_byte = byte_data;
                        res.to_audio     = aud;
                        res.stamp_valid  = hval_reg;
                        res.pts          = pts_reg;
                        res.dts          = dts_reg;
                        res.packet_first = first_reg;
                        res.packet_last  = (left_dec == 17'd0);
                    end
                    default: begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end else begin
                // pes header bytes of the selected stream
                left_next = left_dec;
                unique case (phase_reg)
                    PH_PES_STUFF: begin
                        if (byte_data == 8'hff) begin
                        end else if (byte_data[7:6] == 2'b01) begin
                            phase_next = PH_PES_BUF;
                        end else begin
                            mark_on = 1'b1;
                        end
                    end
                    PH_PES_BUF:   phase_next = PH_PES_MARK;
                    PH_PES_MARK:  mark_on = 1'b1;
                    PH_PES_FLAGS: begin
                        shift_next = {32'd0, byte_data};
                        phase_next = PH_PES_HLEN;
                    end
                    PH_PES_HLEN: begin
                        if (byte_data < {4'd0, need}) begin
                            ev_on = 1'b1;
                        end else begin
                            hleft_next = byte_data - {4'd0, need};
                            m2_next    = 1'b1;
                            if (need != 4'd0) begin
                                scnt_next  = need;
                                dtsf_next  = (need == 4'd10);
                                shift_next = '0;
                                phase_next = PH_PES_STAMP;
                            end else if (hleft_next != 8'd0) begin
                                phase_next = PH_PES_HSKIP;
                            end else if (left_dec == 17'd0) begin
                                phase_next = PH_HUNT;
                            end else begin
                                phase_next = PH_PAYLOAD;
                                first_next = 1'b1;
                            end
                        end
                    end
                    PH_PES_STAMP: begin
                        shift_next = shift_in;
                        scnt_next  = scnt_dec;
                        if (dtsf_reg && scnt_dec == 4'd5)
                            pts_next = decode_stamp(shift_in);
                        if (scnt_dec == 4'd0) begin
                            if (dtsf_reg) begin
                                dts_next = decode_stamp(shift_in);
                            end else begin
                                pts_next = decode_stamp(shift_in);
                                dts_next = decode_stamp(shift_in);
                            end
                            hval_next = 1'b1;
                            if (m2_reg && hleft_reg != 8'd0) begin
                                phase_next = PH_PES_HSKIP;
                            end else if (left_dec == 17'd0) begin
                                phase_next = PH_HUNT;
                            end else begin
                                phase_next = PH_PAYLOAD;
                                first_next = 1'b1;
                            end
                        end
                    end
                    default: begin
                        hleft_next = hleft_dec;
                        if (hleft_dec == 8'd0) begin
                            if (left_dec == 17'd0) begin
                                phase_next = PH_HUNT;
                            end else begin
                                phase_next = PH_PAYLOAD;
                                first_next = 1'b1;
                            end
                        end
                    end
                endcase

                if (mark_on) begin
                    if (mark_c[7:4] == 4'h0) begin
                        if (left_dec == 17'd0) begin
                            phase_next = PH_HUNT;
                        end else begin
                            phase_next = PH_PAYLOAD;
                            first_next = 1'b1;
                        end
                    end else if (mark_c[7:5] == 3'b001) begin
                        shift_next = {32'd0, mark_c};
                        dtsf_next  = mark_c[4];
                        scnt_next  = mark_c[4] ? 4'd9 : 4'd4;
                        m2_next    = 1'b0;
                        phase_next = PH_PES_STAMP;
                    end else if (mark_c[7:6] == 2'b10) begin
                        if (mark_c[5:4] != 2'b00) begin
                            ev_on = 1'b1;
                            ev    = EV_ENCRYPTED;
                        end else begin
                            phase_next = PH_PES_FLAGS;
                        end
                    end else begin
                        ev_on = 1'b1;
                    end
                end

                if (ev_on) begin
                    phase_next    = (left_dec == 17'd0) ? PH_HUNT : PH_SKIP;
                    res_valid     = 1'b1;
                    res.event_res = ev;
                end else if (phase_next >= PH_PES_STUFF && phase_next <= PH_PES_HSKIP &&
                             left_dec == 17'd0) begin
                    phase_next    = PH_HUNT;
                    res_valid     = 1'b1;
                    res.event_res = EV_BAD_HDR;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg  <= 24'hffffff;
            phase_reg <= PH_HUNT;
            id_reg    <= '0;
            left_reg  <= '0;
            hleft_reg <= '0;
            shift_reg <= '0;
            pts_reg   <= '0;
            dts_reg   <= '0;
            ver_reg   <= VER_UNKNOWN;
            halt_reg  <= 1'b0;
            scnt_reg  <= '0;
            dtsf_reg  <= 1'b0;
            m2_reg    <= 1'b0;
            hval_reg  <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            sync_reg  <= sync_next;
            phase_reg <= phase_next;
            id_reg    <= id_next;
            left_reg  <= left_next;
            hleft_reg <= hleft_next;
            shift_reg <= shift_next;
            pts_reg   <= pts_next;
            dts_reg   <= dts_next;
            ver_reg   <= ver_next;
            halt_reg  <= halt_next;
            scnt_reg  <= scnt_next;
            dtsf_reg  <= dtsf_next;
            m2_reg    <= m2_next;
            hval_reg  <= hval_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- rtl/core/mpd_queue.sv -----
// back part: short result queue between parser and output channel
`timescale 1ns / 1ps
module mpd_queue
    import mpd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    input  res_t wr_data,
    output logic space,
    output logic rd_valid,
    input  logic rd_ready,
    output res_t rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    res_t          mem [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          do_wr, do_rd;

    assign do_wr    = wr_valid;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem[rp_reg];
    // input held off only while every entry is taken
    assign space    = (cnt_reg != (AW+1)'(DEPTH));

    always_comb begin
        wp_next  = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        rp_next  = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        cnt_next = cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end

    always_ff @(posedge aclk) begin
        if (do_wr) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= wp_next;
            if (do_rd) rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- rtl/core/mpd_checker.sv -----
// port checker for the demultiplexer top level, with its bind
`timescale 1ns / 1ps
module mpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [87:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_last_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == 3'd0)
        else $error("last flag on an event item");

    a_event_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[2:0] != 3'd0 |-> m_axis_tdata[79:3] == '0)
        else $error("event item carries payload fields");

    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result item right after reset");

    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind mpeg_ps_pes_demux_core mpd_checker u_mpd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);

// ----- sim/mpeg_ps_pes_demux_core_test.sv -----
// testbench: program stream demultiplexer checked against a byte-wise parser model
`timescale 1ns / 1ps
module mpeg_ps_pes_demux_core_test;
    import mpd_pkg::*;

    localparam int F1_NONE = 0, F1_PTS = 1, F1_BOTH = 2, F1_BADMARK = 3;
    localparam int F2_NONE = 4, F2_PTS = 5, F2_BOTH = 6, F2_ENC = 7, F2_SHORTHLEN = 8;
    localparam int LEN_OK = 0, LEN_ZERO = 1, LEN_HDR_ONLY = 2, LEN_TRUNC = 3;

    typedef enum logic [3:0] {
        P_HUNT, P_PACK_B4, P_PACK_FIX, P_PACK_STUFF, P_LEN_HI, P_LEN_LO, P_SKIP,
        P_PAYLOAD, P_PES_STUFF, P_PES_BUF, P_PES_MARK, P_PES_FLAGS, P_PES_HLEN,
        P_PES_STAMP, P_PES_HSKIP
    } parse_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [4:0]  cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [87:0] m_axis_tdata;
    logic        m_axis_tlast;

    mpeg_ps_pes_demux_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // demux model state
    logic [3:0]   video_sel = '0;
    logic [4:0]   audio_sel = '0;
    logic         raw_start = 1'b0;
    logic [23:0]  sync_win = 24'hffffff;
    parse_phase_t phase = P_HUNT;
    logic [7:0]   pkt_id = '0;
    logic [16:0]  bytes_left = '0;
    logic [7:0]   hdr_left = '0;
    logic [39:0]  shift_reg = '0;
    logic [32:0]  held_pts = '0;
    logic [32:0]  held_dts = '0;
    logic [1:0]   ver_seen = '0;
    logic         halted = 1'b0;
    int           stamp_cnt = 0;
    logic         dts_follows = 1'b0;
    logic         in_mpeg2 = 1'b0;
    logic         held_valid = 1'b0;
    logic         first_pending = 1'b0;

    res_t expected_results[$];
    int   errors = 0;
    bit   fast = 1'b0;
    int   sent = 0;
    logic [7:0] body[$];

    function automatic logic [32:0] stamp_of(input logic [39:0] s);
        logic [32:0] v;
        v[32:30] = s[35:33];
        v[29:15] = s[31:17];
        v[14:0]  = s[15:1];
        return v;
    endfunction

    function logic raw_on();
        return raw_start || ver_seen == VER_RAW;
    endfunction

    function void skip_rest();
        phase = (bytes_left == 0) ? P_HUNT : P_SKIP;
    endfunction

    function void header_finished();
        if (bytes_left == 0) begin
            phase = P_HUNT;
        end else begin
            phase = P_PAYLOAD;
            first_pending = 1'b1;
        end
    endfunction

    function void stamps_finished();
        if (in_mpeg2 && hdr_left != 0) phase = P_PES_HSKIP;
        else header_finished();
    endfunction

    // returns an event code, or -1
    function int marker_check(input logic [7:0] c);
        if (c[7:4] == 4'd0) begin
            header_finished();
        end else if (c[7:4] == 4'd2 || c[7:4] == 4'd3) begin
            shift_reg = {32'd0, c};
            dts_follows = (c[7:4] == 4'd3);
            stamp_cnt = dts_follows ? 9 : 4;
            in_mpeg2 = 1'b0;
            phase = P_PES_STAMP;
        end else if (c[7:6] == 2'b10) begin
            if (c[5:4] != 2'b00) return EV_ENCRYPTED;
            phase = P_PES_FLAGS;
        end else begin
            return EV_BAD_HDR;
        end
        return -1;
    endfunction

    function res_t event_item(input logic [2:0] e);
        res_t r;
        r = '0;
        r.event_res = e;
        r.mpeg_version = raw_on() ? VER_RAW : ver_seen;
        return r;
    endfunction

    function bit demux_byte(input logic [7:0] c, output res_t r);
        logic aud;
        int   ev;
        int   need;
        logic first;
        r = '0;
        aud = (pkt_id[7:5] == 3'b110);
        ev = -1;
        if (halted) return 0;
        if (raw_on()) begin
            r.payload_byte = c;
            r.mpeg_version = VER_RAW;
            return 1;
        end
        case (phase)
            P_HUNT: begin
                if (sync_win != 24'h000001) begin
                    sync_win = {sync_win[15:0], c};
                    return 0;
                end
                sync_win = 24'hffffff;
                pkt_id = c;
                if (c == ID_PROG_END) begin
                    halted = 1'b1;
                    r = event_item(EV_PROG_END);
                    return 1;
                end
                if (c == ID_PACK) begin
                    phase = P_PACK_B4;
                end else if (c >= ID_RAW_LO && c < ID_PROG_END) begin
                    ver_seen = VER_RAW;
                    r = event_item(EV_PAYLOAD);
                    r.payload_byte = c;
                    r.packet_first = 1'b1;
                    return 1;
                end else begin
                    phase = P_LEN_HI;
                end
                return 0;
            end
            P_PACK_B4: begin
                if (c[7:6] == 2'b01) begin
                    ver_seen = VER_MPEG2;
                    hdr_left = 8;
                    phase = P_PACK_FIX;
                end else if (c[7:4] == 4'b0010) begin
                    ver_seen = VER_MPEG1;
                    bytes_left = 7;
                    phase = P_SKIP;
                end else begin
                    halted = 1'b1;
                    r = event_item(EV_NOT_MPEG);
                    return 1;
                end
                return 0;
            end
            P_PACK_FIX: begin
                hdr_left = hdr_left - 1;
                if (hdr_left == 0) phase = P_PACK_STUFF;
                return 0;
            end
            P_PACK_STUFF: begin
                bytes_left = c[2:0];
                skip_rest();
                return 0;
            end
            P_LEN_HI: begin
                bytes_left = {1'b0, c, 8'd0};
                phase = P_LEN_LO;
                return 0;
            end
            P_LEN_LO: begin
                bytes_left[7:0] = c;
                if ((pkt_id[7:5] == 3'b110 && pkt_id[4:0] == audio_sel) ||
                    (pkt_id[7:4] == 4'he && pkt_id[3:0] == video_sel)) begin
                    held_pts = '0;
                    held_dts = '0;
                    held_valid = 1'b0;
                    in_mpeg2 = 1'b0;
                    if (bytes_left == 0) begin
                        phase = P_HUNT;
                        r = event_item(EV_BAD_HDR);
                        return 1;
                    end
                    phase = P_PES_STUFF;
                end else begin
                    skip_rest();
                end
                return 0;
            end
            P_SKIP: begin
                if (bytes_left != 0) bytes_left--;
                if (bytes_left == 0) phase = P_HUNT;
                return 0;
            end
            P_PAYLOAD: begin
                first = first_pending;
                if (bytes_left != 0) bytes_left--;
                first_pending = 1'b0;
                if (bytes_left == 0) phase = P_HUNT;
                r = event_item(EV_PAYLOAD);
                r.payload_byte = c;
                r.to_audio = aud;
                r.stamp_valid = held_valid;
                r.pts = held_pts;
                r.dts = held_dts;
                r.packet_first = first;
                r.packet_last = (bytes_left == 0);
                return 1;
            end
            default: ;
        endcase

        // pes header of the selected stream
        if (bytes_left != 0) bytes_left--;
        case (phase)
            P_PES_STUFF: begin
                if (c != 8'hff) begin
                    if (c[7:6] == 2'b01) phase = P_PES_BUF;
                    else ev = marker_check(c);
                end
            end
            P_PES_BUF: phase = P_PES_MARK;
            P_PES_MARK: ev = marker_check(c);
            P_PES_FLAGS: begin
                shift_reg = {32'd0, c};
                phase = P_PES_HLEN;
            end
            P_PES_HLEN: begin
                need = (shift_reg[7:6] == 2'b10) ? 5 : (shift_reg[7:6] == 2'b11) ? 10 : 0;
                if (c < need) begin
                    ev = EV_BAD_HDR;
                end else begin
                    hdr_left = c - need;
                    in_mpeg2 = 1'b1;
                    if (need != 0) begin
                        stamp_cnt = need;
                        dts_follows = (need == 10);
                        shift_reg = '0;
                        phase = P_PES_STAMP;
                    end else begin
                        stamps_finished();
                    end
                end
            end
            P_PES_STAMP: begin
                shift_reg = {shift_reg[31:0], c};
                if (stamp_cnt != 0) stamp_cnt--;
                if (dts_follows && stamp_cnt == 5) held_pts = stamp_of(shift_reg);
                if (stamp_cnt == 0) begin
                    if (dts_follows) begin
                        held_dts = stamp_of(shift_reg);
                    end else begin
                        held_pts = stamp_of(shift_reg);
                        held_dts = held_pts;
                    end
                    held_valid = 1'b1;
                    stamps_finished();
                end
            end
            default: begin
                if (hdr_left != 0) hdr_left--;
                if (hdr_left == 0) header_finished();
            end
        endcase
        if (ev >= 0) begin
            skip_rest();
            r = event_item(ev[2:0]);
            return 1;
        end
        if (phase >= P_PES_STUFF && bytes_left == 0) begin
            phase = P_HUNT;
            r = event_item(EV_BAD_HDR);
            return 1;
        end
        return 0;
    endfunction

    // result side: random stall per item, checks in order
    int stall = 0;
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_axis_tvalid && m_ready) begin
            got.event_res    = m_axis_tdata[2:0];
            got.payload_byte = m_axis_tdata[10:3];
            got.to_audio     = m_axis_tdata[11];
            got.stamp_valid  = m_axis_tdata[12];
            got.pts          = m_axis_tdata[45:13];
            got.dts          = m_axis_tdata[78:46];
            got.packet_first = m_axis_tdata[79];
            got.mpeg_version = m_axis_tdata[81:80];
            got.packet_last  = m_axis_tlast;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, actual %h", $time, got);
            end else begin
                want = expected_results.pop_front();
                check_field("event_res", want.event_res, got.event_res);
                check_field("payload_byte", want.payload_byte, got.payload_byte);
                check_field("to_audio", want.to_audio, got.to_audio);
                check_field("stamp_valid", want.stamp_valid, got.stamp_valid);
                check_field("pts", want.pts, got.pts);
                check_field("dts", want.dts, got.dts);
                check_field("packet_first", want.packet_first, got.packet_first);
                check_field("packet_last", want.packet_last, got.packet_last);
                check_field("mpeg_version", want.mpeg_version, got.mpeg_version);
            end
            stall = fast ? 0 : $urandom_range(0, 19);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(input string nm, input logic [32:0] e, input logic [32:0] a);
        if (e !== a) begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, nm, e, a);
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        int   gap;
        res_t r;
        gap = fast ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= b;
        do @(posedge aclk); while (!s_axis_tready);
        if (demux_byte(b, r)) expected_results.push_back(r);
        sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_VIDEO_SEL: video_sel = val[3:0];
            CFG_AUDIO_SEL: audio_sel = val;
            CFG_RAW_START: raw_start = val[0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic send_start(input logic [7:0] id);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(id);
    endtask

    task automatic send_pack(input bit mpeg2);
        int i;
        int stuff;
        send_start(ID_PACK);
        if (mpeg2) begin
            send_byte({2'b01, 6'($urandom)});
            for (i = 0; i < 8; i++) send_byte(8'($urandom));
            stuff = $urandom_range(0, 7);
            send_byte({5'($urandom), 3'(stuff)});
            for (i = 0; i < stuff; i++) send_byte(8'hff);
        end else begin
            send_byte({4'b0010, 4'($urandom)});
            for (i = 0; i < 7; i++) send_byte(8'($urandom));
        end
    endtask

    // skipped packet of any id
    task automatic send_other(input logic [7:0] id, input int len);
        int i;
        send_start(id);
        send_byte(8'(len >> 8));
        send_byte(8'(len));
        for (i = 0; i < len; i++) send_byte(8'($urandom));
    endtask

    task automatic send_pes(input logic [7:0] id, input int form, input int plen,
                            input int lenmode);
        int i;
        int h;
        int len;
        int need;
        body.delete();
        if (form <= F1_BADMARK) begin
            repeat ($urandom_range(0, 3)) body.push_back(8'hff);
            if ($urandom_range(0, 1)) begin
                body.push_back({2'b01, 6'($urandom)});
                body.push_back(8'($urandom));
            end
            case (form)
                F1_NONE: body.push_back({4'h0, 4'($urandom)});
                F1_PTS: begin
                    body.push_back({4'h2, 4'($urandom)});
                    repeat (4) body.push_back(8'($urandom));
                end
                F1_BOTH: begin
                    body.push_back({4'h3, 4'($urandom)});
                    repeat (9) body.push_back(8'($urandom));
                end
                default: body.push_back($urandom_range(0, 1) ? {4'h1, 4'($urandom)}
                                        : 8'($urandom_range(8'hc0, 8'hfe)));
            endcase
        end else begin
            if (form == F2_ENC)
                body.push_back({2'b10, 2'($urandom_range(1, 3)), 4'($urandom)});
            else
                body.push_back({4'b1000, 4'($urandom)});
            need = (form == F2_PTS) ? 5 : (form == F2_BOTH || form == F2_SHORTHLEN) ? 10 : 0;
            if (need == 5) body.push_back({2'b10, 6'($urandom)});
            else if (need == 10) body.push_back({2'b11, 6'($urandom)});
            else body.push_back({1'b0, 7'($urandom)});
            if (form == F2_SHORTHLEN) begin
                body.push_back(8'($urandom_range(0, 9)));
            end else begin
                h = $urandom_range(0, 3);
                body.push_back(8'(need + h));
                repeat (need + h) body.push_back(8'($urandom));
            end
        end
        h = body.size();
        for (i = 0; i < plen; i++) body.push_back(8'($urandom));
        case (lenmode)
            LEN_ZERO: len = 0;
            LEN_HDR_ONLY: len = h;
            LEN_TRUNC: len = (h > 1) ? $urandom_range(1, h - 1) : 1;
            default: len = body.size();
        endcase
        send_start(id);
        send_byte(8'(len >> 8));
        send_byte(8'(len));
        for (i = 0; i < len && i < body.size(); i++) send_byte(body[i]);
    endtask

    function logic [7:0] video_id();
        return {4'he, video_sel};
    endfunction

    function logic [7:0] audio_id();
        return {3'b110, audio_sel};
    endfunction

    task automatic test_packs();
        send_pack(1'b1);
        send_pack(1'b0);
        send_pes(video_id(), F2_BOTH, 3, LEN_OK);
        send_pack(1'b1);
        send_pes(audio_id(), F1_PTS, 2, LEN_OK);
    endtask

    task automatic test_header_forms();
        int f;
        for (f = F1_NONE; f <= F1_BOTH; f++) send_pes(audio_id(), f, 2, LEN_OK);
        wait_idle();
        for (f = F2_NONE; f <= F2_BOTH; f++) send_pes(video_id(), f, 2, LEN_OK);
        send_pes(audio_id(), F2_PTS, 1, LEN_OK);
    endtask

    task automatic test_broken_headers();
        send_pes(video_id(), F2_ENC, 4, LEN_OK);
        send_pes(audio_id(), F1_BADMARK, 4, LEN_OK);
        send_pes(video_id(), F2_SHORTHLEN, 4, LEN_OK);
        send_pes(video_id(), F1_BOTH, 0, LEN_ZERO);
        send_pes(audio_id(), F2_BOTH, 4, LEN_TRUNC);
        send_pes(video_id(), F2_PTS, 4, LEN_HDR_ONLY);
        send_pes(audio_id(), F1_NONE, 4, LEN_HDR_ONLY);
    endtask

    task automatic test_skipped_packets();
        send_other(8'hbb, 6);
        send_other(8'hbe, 5);
        send_other(8'hbd, 4);
        send_other(video_id() ^ 8'h01, 3);
        send_other(audio_id() ^ 8'h01, 3);
        send_other(8'hf3, 0);
        send_pes(video_id(), F2_NONE, 2, LEN_OK);
    endtask

    task automatic test_raw_start();
        write_reg(CFG_RAW_START, 5'd1);
        repeat (12) send_byte(8'($urandom));
        write_reg(CFG_RAW_START, 5'd0);
    endtask

    task automatic test_random(input int budget);
        int start;
        int k;
        int f;
        int plen;
        start = sent;
        while (sent - start < budget) begin
            if ($urandom_range(0, 9) == 0) fast = ~fast;
            k = $urandom_range(0, 99);
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 8);
            if (k < 65) begin
                f = $urandom_range(F2_NONE, F2_BOTH);
                if ($urandom_range(0, 1)) f = $urandom_range(F1_NONE, F1_BOTH);
                send_pes($urandom_range(0, 1) ? video_id() : audio_id(), f, plen, LEN_OK);
            end else if (k < 75) begin
                send_pes($urandom_range(0, 1) ? video_id() : audio_id(),
                         $urandom_range(F1_NONE, F2_SHORTHLEN), plen,
                         $urandom_range(LEN_OK, LEN_TRUNC));
            end else if (k < 85) begin
                do f = $urandom_range(0, 255);
                while (f == ID_PACK || (f >= ID_RAW_LO && f <= ID_PROG_END));
                send_other(8'(f), $urandom_range(0, 10));
            end else if (k < 92) begin
                send_pack($urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            end
        end
        fast = 1'b0;
    endtask

    // program end, bad pack and raw switch all stick until reset, so one is picked
    task automatic test_terminal();
        int mode;
        int b;
        mode = $urandom_range(0, 2);
        if (mode == 0) begin
            send_start(ID_PROG_END);
        end else if (mode == 1) begin
            send_start(ID_PACK);
            do b = $urandom_range(0, 255);
            while (b[7:6] == 2'b01 || b[7:4] == 4'b0010);
            send_byte(8'(b));
        end else begin
            send_start(8'($urandom_range(ID_RAW_LO, ID_PROG_END - 1)));
        end
        repeat (10) send_byte(8'($urandom));
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_packs();
        write_reg(CFG_VIDEO_SEL, 5'd15);
        write_reg(CFG_AUDIO_SEL, 5'd31);
        test_header_forms();
        test_broken_headers();
        write_reg(CFG_VIDEO_SEL, 5'd0);
        write_reg(CFG_AUDIO_SEL, 5'd0);
        test_skipped_packets();
        test_raw_start();
        write_reg(CFG_VIDEO_SEL, 5'($urandom_range(0, 15)));
        write_reg(CFG_AUDIO_SEL, 5'($urandom_range(0, 31)));
        test_random(30);
        write_reg(CFG_VIDEO_SEL, 5'd15);
        test_random(30);
        test_terminal();
        wait_idle();
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("mpeg_ps_pes_demux_core_test OK");
        end else begin
            $display("mpeg_ps_pes_demux_core_test NOT OK");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("mpeg_ps_pes_demux_core_test NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/mpd_pkg.sv
rtl/core/mpd_parse.sv
rtl/core/mpd_queue.sv
rtl/core/mpeg_ps_pes_demux_core.sv
rtl/core/mpd_checker.sv
sim/mpeg_ps_pes_demux_core_test.sv
